[src/ptw_pkg.sv]
package ptw_pkg;

  localparam int unsigned IDX_W    = 9;
  localparam int unsigned OFF_W    = 12;
  localparam int unsigned ENTRY_W  = 64;
  localparam int unsigned VA_W     = 48;
  localparam int unsigned PA_W     = 52;
  localparam int unsigned SHIFT_L0 = 39;
  localparam int unsigned SHIFT_L1 = 30;
  localparam int unsigned SHIFT_L2 = 21;
  localparam int unsigned SHIFT_L3 = 12;
  localparam logic [OFF_W-1:0] PTR_BITS = 12'h003;

  typedef enum logic [2:0] {
    OP_MAP       = 3'd0,
    OP_UNMAP     = 3'd1,
    OP_TRANSLATE = 3'd2,
    OP_SET_FLAGS = 3'd3,
    OP_GET_FLAGS = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ALIGN      = 3'd1,
    ST_EXHAUSTED  = 3'd2,
    ST_ALREADY    = 3'd3,
    ST_NOT_MAPPED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_READ,
    S_WAIT,
    S_ZERO,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    WR_LEAF_MAP,
    WR_LEAF_CLR,
    WR_LEAF_FLAGS
  } wr_sel_t;

  typedef struct packed {
    logic    load_req;
    logic    rd;
    logic    alloc;
    logic    zero_wr;
    logic    descend_ptr;
    logic    descend_zero;
    logic    leaf_wr;
    wr_sel_t wr_sel;
    logic    finish;
    status_t status;
    logic    give_xlat;
    logic    give_flags;
    logic    flush;
    logic    load_out;
  } ctl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic va_aligned;
    logic pa_aligned;
    logic ent_present;
    logic ent_in_range;
    logic pool_full;
    logic zero_last;
    logic level_last;
    logic out_free;
  } ctl_sts_t;

endpackage

[src/ptw_ctrl.sv]
module ptw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  ptw_pkg::ctl_sts_t sts,
  output ptw_pkg::ctl_cmd_t cmd
);

  ptw_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptw_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ptw_pkg::S_CLEAR: begin
        if (sts.zero_last) state_nxt = ptw_pkg::S_IDLE;
      end
      ptw_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = ptw_pkg::S_CHECK;
      end
      ptw_pkg::S_CHECK: begin
        case (sts.op)
          ptw_pkg::OP_MAP:
            state_nxt = (sts.va_aligned && sts.pa_aligned) ? ptw_pkg::S_READ : ptw_pkg::S_DONE;
          ptw_pkg::OP_UNMAP, ptw_pkg::OP_SET_FLAGS:
            state_nxt = sts.va_aligned ? ptw_pkg::S_READ : ptw_pkg::S_DONE;
          ptw_pkg::OP_TRANSLATE, ptw_pkg::OP_GET_FLAGS:
            state_nxt = ptw_pkg::S_READ;
          default:
            state_nxt = ptw_pkg::S_DONE;
        endcase
      end
      ptw_pkg::S_READ: state_nxt = ptw_pkg::S_WAIT;
      ptw_pkg::S_WAIT: begin
        state_nxt = ptw_pkg::S_DONE;
        if (!sts.level_last) begin
          if (sts.ent_present) begin
            if (sts.ent_in_range) state_nxt = ptw_pkg::S_READ;
          end else if (sts.op == ptw_pkg::OP_MAP && !sts.pool_full) begin
            state_nxt = ptw_pkg::S_ZERO;
          end
        end
      end
      ptw_pkg::S_ZERO: begin
        if (sts.zero_last) state_nxt = ptw_pkg::S_READ;
      end
      ptw_pkg::S_DONE: begin
        if (sts.out_free) state_nxt = ptw_pkg::S_IDLE;
      end
      default: state_nxt = ptw_pkg::S_CLEAR;
    endcase
  end

  // command outputs
  always_comb begin
    cmd        = '0;
    cmd.wr_sel = ptw_pkg::WR_LEAF_MAP;
    cmd.status = ptw_pkg::ST_OK;
    in_tready  = 1'b0;
    case (state_r)
      ptw_pkg::S_CLEAR: cmd.zero_wr = 1'b1;
      ptw_pkg::S_IDLE: begin
        in_tready    = 1'b1;
        cmd.load_req = in_tvalid;
      end
      ptw_pkg::S_CHECK: begin
        case (sts.op)
          ptw_pkg::OP_MAP: begin
            if (!(sts.va_aligned && sts.pa_aligned)) begin
              cmd.finish = 1'b1;
              cmd.status = ptw_pkg::ST_ALIGN;
            end
          end
          ptw_pkg::OP_UNMAP, ptw_pkg::OP_SET_FLAGS: begin
            if (!sts.va_aligned) begin
              cmd.finish = 1'b1;
              cmd.status = ptw_pkg::ST_ALIGN;
            end
          end
          ptw_pkg::OP_TRANSLATE, ptw_pkg::OP_GET_FLAGS: ;
          default: cmd.finish = 1'b1;
        endcase
      end
      ptw_pkg::S_READ: cmd.rd = 1'b1;
      ptw_pkg::S_WAIT: begin
        if (!sts.level_last) begin
          if (sts.ent_present) begin
            if (sts.ent_in_range) begin
              cmd.descend_ptr = 1'b1;
            end else begin
              cmd.finish = 1'b1;
              cmd.status = ptw_pkg::ST_NOT_MAPPED;
            end
          end else if (sts.op != ptw_pkg::OP_MAP) begin
            cmd.finish = 1'b1;
            cmd.status = ptw_pkg::ST_NOT_MAPPED;
          end else if (sts.pool_full) begin
            cmd.finish = 1'b1;
            cmd.status = ptw_pkg::ST_EXHAUSTED;
          end else begin
            cmd.alloc = 1'b1;
          end
        end else begin
          cmd.finish = 1'b1;
          case (sts.op)
            ptw_pkg::OP_MAP: begin
              if (sts.ent_present) begin
                cmd.status = ptw_pkg::ST_ALREADY;
              end else begin
                cmd.leaf_wr = 1'b1;
                cmd.wr_sel  = ptw_pkg::WR_LEAF_MAP;
                cmd.flush   = 1'b1;
              end
            end
            ptw_pkg::OP_UNMAP: begin
              if (!sts.ent_present) begin
                cmd.status = ptw_pkg::ST_NOT_MAPPED;
              end else begin
                cmd.leaf_wr = 1'b1;
                cmd.wr_sel  = ptw_pkg::WR_LEAF_CLR;
                cmd.flush   = 1'b1;
              end
            end
            ptw_pkg::OP_SET_FLAGS: begin
              if (!sts.ent_present) begin
                cmd.status = ptw_pkg::ST_NOT_MAPPED;
              end else begin
                cmd.leaf_wr = 1'b1;
                cmd.wr_sel  = ptw_pkg::WR_LEAF_FLAGS;
                cmd.flush   = 1'b1;
              end
            end
            ptw_pkg::OP_TRANSLATE: begin
              if (!sts.ent_present) cmd.status = ptw_pkg::ST_NOT_MAPPED;
              else cmd.give_xlat = 1'b1;
            end
            ptw_pkg::OP_GET_FLAGS: begin
              if (!sts.ent_present) cmd.status = ptw_pkg::ST_NOT_MAPPED;
              else cmd.give_flags = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ptw_pkg::S_ZERO: begin
        cmd.zero_wr      = 1'b1;
        cmd.descend_zero = sts.zero_last;
      end
      ptw_pkg::S_DONE: cmd.load_out = sts.out_free;
      default: ;
    endcase
  end

endmodule

[src/ptw_datapath.sv]
module ptw_datapath #(
  parameter int unsigned TABLE_COUNT = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ptw_pkg::ctl_cmd_t cmd,
  output ptw_pkg::ctl_sts_t sts,
  input  logic [2:0]        req_opcode,
  input  logic [47:0]       req_va,
  input  logic [51:0]       req_pa,
  input  logic [11:0]       req_flags,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [2:0]        out_status,
  output logic [51:0]       out_xlat,
  output logic [11:0]       out_flags,
  output logic              out_flush
);

  localparam int unsigned TBW   = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
  localparam int unsigned NFW   = $clog2(TABLE_COUNT + 1);
  localparam int unsigned AW    = TBW + ptw_pkg::IDX_W;
  localparam int unsigned DEPTH = TABLE_COUNT * (1 << ptw_pkg::IDX_W);

  logic [ptw_pkg::ENTRY_W-1:0] mem [DEPTH];

  logic [2:0]                  op_r;
  logic [47:0]                 va_r;
  logic [51:0]                 pa_r;
  logic [11:0]                 fl_r;
  logic [TBW-1:0]              tbl_r;
  logic [1:0]                  level_r;
  logic [AW-1:0]               addr_r;
  logic [ptw_pkg::ENTRY_W-1:0] rdata_r;
  logic [NFW-1:0]              next_free_r;
  logic [TBW-1:0]              ztbl_r;
  logic [ptw_pkg::IDX_W-1:0]   zcnt_r;
  logic [2:0]                  res_status_r;
  logic [51:0]                 res_xlat_r;
  logic [11:0]                 res_flags_r;
  logic                        res_flush_r;
  logic                        out_tvalid_r;
  logic [2:0]                  out_status_r;
  logic [51:0]                 out_xlat_r;
  logic [11:0]                 out_flags_r;
  logic                        out_flush_r;

  logic [ptw_pkg::IDX_W-1:0]   idx;
  logic [AW-1:0]               raddr;
  logic                        we;
  logic [AW-1:0]               waddr;
  logic [ptw_pkg::ENTRY_W-1:0] wdata;
  logic                        pool_full;

  function automatic logic [ptw_pkg::IDX_W-1:0] req_va_sel(input int unsigned sh);
    req_va_sel = va_r[sh +: ptw_pkg::IDX_W];
  endfunction

  always_comb begin
    case (level_r)
      2'd0:    idx = req_va_sel(ptw_pkg::SHIFT_L0);
      2'd1:    idx = req_va_sel(ptw_pkg::SHIFT_L1);
      2'd2:    idx = req_va_sel(ptw_pkg::SHIFT_L2);
      default: idx = req_va_sel(ptw_pkg::SHIFT_L3);
    endcase
  end

  assign raddr     = {tbl_r, idx};
  assign pool_full = (next_free_r >= NFW'(TABLE_COUNT));

  always_comb begin
    we    = cmd.zero_wr || cmd.alloc || cmd.leaf_wr;
    waddr = cmd.zero_wr ? {ztbl_r, zcnt_r} : addr_r;
    if (cmd.zero_wr) begin
      wdata = '0;
    end else if (cmd.alloc) begin
      wdata = ptw_pkg::ENTRY_W'({next_free_r[TBW-1:0], ptw_pkg::PTR_BITS});
    end else begin
      case (cmd.wr_sel)
        ptw_pkg::WR_LEAF_MAP:   wdata = ptw_pkg::ENTRY_W'({pa_r[51:12], fl_r});
        ptw_pkg::WR_LEAF_FLAGS: wdata = {rdata_r[63:12], fl_r};
        default:                wdata = '0;
      endcase
    end
  end

  // table pool
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_free_r  <= NFW'(1);
      ztbl_r       <= '0;
      zcnt_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cmd.alloc) begin
        next_free_r <= next_free_r + NFW'(1);
        ztbl_r      <= next_free_r[TBW-1:0];
        zcnt_r      <= '0;
      end else if (cmd.zero_wr) begin
        zcnt_r <= zcnt_r + 1'b1;
      end
      if (cmd.load_out) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r    <= req_opcode;
      va_r    <= req_va;
      pa_r    <= req_pa;
      fl_r    <= req_flags;
      tbl_r   <= '0;
      level_r <= '0;
    end else if (cmd.descend_ptr) begin
      tbl_r   <= rdata_r[12 +: TBW];
      level_r <= level_r + 2'd1;
    end else if (cmd.descend_zero) begin
      tbl_r   <= ztbl_r;
      level_r <= level_r + 2'd1;
    end
    if (cmd.rd) addr_r <= raddr;
    if (cmd.finish) begin
      res_status_r <= cmd.status;
      res_xlat_r   <= cmd.give_xlat ? {rdata_r[51:12], va_r[11:0]} : '0;
      res_flags_r  <= cmd.give_flags ? rdata_r[11:0] : '0;
      res_flush_r  <= cmd.flush;
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_xlat_r   <= res_xlat_r;
      out_flags_r  <= res_flags_r;
      out_flush_r  <= res_flush_r;
    end
  end

  always_comb begin
    sts.op           = ptw_pkg::op_t'(op_r);
    sts.va_aligned   = (va_r[11:0] == '0);
    sts.pa_aligned   = (pa_r[11:0] == '0);
    sts.ent_present  = rdata_r[0];
    sts.ent_in_range = (rdata_r[63:12] < 52'(TABLE_COUNT));
    sts.pool_full    = pool_full;
    sts.zero_last    = (zcnt_r == '1);
    sts.level_last   = (level_r == 2'd3);
    sts.out_free     = !out_tvalid_r || out_tready;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_status = out_status_r;
  assign out_xlat   = out_xlat_r;
  assign out_flags  = out_flags_r;
  assign out_flush  = out_flush_r;

  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r <= NFW'(TABLE_COUNT))
    else $error("allocator ran past the pool");

  a_alloc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc |-> !pool_full)
    else $error("allocation with pool full");

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.zero_wr, cmd.alloc, cmd.leaf_wr}) <= 1)
    else $error("two writes to the pool in one cycle");

endmodule

[src/four_level_page_table_walker.sv]
// four-level page table walker with an internal table pool
// in channel: one request per handshake (map, unmap, translate, set flags,
//   get flags); in_tready is high only while the walker is idle
// out channel: one result per request, held in an output register until taken
// allocation: each table the walk allocates is zeroed before the walk descends into it
// requests: one at a time; each level of the walk waits on its table pool
//   read, and the next request is taken only once the walker is idle again
// reset: the root table is cleared one entry a cycle, with in_tready low;
//   the allocator restarts at table 1
// stall: a result waiting on out_tready does not block the next request;
//   the walker only holds in its final step until the output register frees
module four_level_page_table_walker #(
  parameter int unsigned TABLE_COUNT = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode[2:0], virtual_address[50:3], physical_address[102:51],
  // page_flags[114:103], zero pad
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[2:0], translated_address[54:3], flags_out[66:55], flush_page[67],
  // zero pad
  output logic [71:0]  out_tdata
);

  ptw_pkg::ctl_cmd_t cmd;
  ptw_pkg::ctl_sts_t sts;

  logic [2:0]  out_status;
  logic [51:0] out_xlat;
  logic [11:0] out_flags;
  logic        out_flush;

  // controller sequences the walk
  ptw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // request registers, table pool, allocator, result registers
  ptw_datapath #(
    .TABLE_COUNT (TABLE_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .req_opcode (in_tdata[2:0]),
    .req_va     (in_tdata[50:3]),
    .req_pa     (in_tdata[102:51]),
    .req_flags  (in_tdata[114:103]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (out_status),
    .out_xlat   (out_xlat),
    .out_flags  (out_flags),
    .out_flush  (out_flush)
  );

  assign out_tdata = {4'b0, out_flush, out_flags, out_xlat, out_status};

endmodule
